### rtl/cngh_pkg.sv
// Shared types, constants and the FNV-1a step for the character n-gram hasher.
`timescale 1ns / 1ps

package cngh_pkg;

  localparam int unsigned MAX_GRAM_LEN_DEF = 8;
  localparam int unsigned RESULT_CAP       = 16;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned GRAM_W   = 4;
  localparam int unsigned ROW_W    = 25;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [GRAM_W-1:0] MIN_GRAM_RST     = 4'd3;
  localparam logic [GRAM_W-1:0] MAX_GRAM_RST     = 4'd6;
  localparam logic [ROW_W-1:0]  BUCKET_COUNT_RST = 25'd2000000;
  localparam logic [ROW_W-1:0]  VOCAB_WORDS_RST  = 25'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GRAM     = 2'd0,
    CFG_MAX_GRAM     = 2'd1,
    CFG_BUCKET_COUNT = 2'd2,
    CFG_VOCAB_WORDS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              text_end;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [GRAM_W-1:0] gram_length;
    logic              last_of_run;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [CHAR_W-1:0] c);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-CHAR_W){1'b0}}, c};
    return x * FNV_PRIME;
  endfunction

endpackage

### rtl/cngh_rem_unit.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo 25-bit divisor.
`timescale 1ns / 1ps

module cngh_rem_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cngh_pkg::HASH_W-1:0]   dividend_i,
  input  logic [cngh_pkg::ROW_W-1:0]    divisor_i,
  output cngh_pkg::rem_stat_t           stat_o,
  output logic [cngh_pkg::ROW_W-1:0]    rem_o
);
  import cngh_pkg::*;

  localparam int unsigned CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0] quo_q;
  logic [ROW_W:0]    part_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [ROW_W:0]    part_sh;
  logic [ROW_W:0]    part_sub;
  logic              take;

  assign part_sh  = {part_q[ROW_W-1:0], quo_q[HASH_W-1]};
  assign take     = part_sh >= {1'b0, divisor_i};
  assign part_sub = part_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HASH_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      part_q <= '0;
    end else if (busy_q) begin
      quo_q  <= {quo_q[HASH_W-2:0], 1'b0};
      part_q <= take ? part_sub : part_sh;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = part_q[ROW_W-1:0];

endmodule

### rtl/char_ngram_bucket_hasher.sv
// Top level of the character n-gram bucket hasher.
`timescale 1ns / 1ps

// Takes text one byte per transfer, folds A-Z to lower case, frames each word
// as '<' word '>' and, for every framed character appended, hashes every
// n-gram ending there with length in [min_gram, max_gram] using 32-bit FNV-1a,
// giving vocab_words + (hash mod bucket_count) per gram, shortest first, for at
// most 16 results per byte, with last_of_run on the final result of a byte.
// For each byte the sequencer appends each framed character in turn and, for
// each gram, hashes its characters one by one in the shared xor-multiply unit,
// reduces the hash in the bit-serial remainder unit (skipped when bucket_count
// is zero, which uses the low 25 hash bits) and hands the result on; a stalled
// output holds the sequencer for as long as it stalls. in_ready_o stays low
// until the byte's last result has been handed to the output register.
module char_ngram_bucket_hasher #(
  parameter int unsigned MAX_GRAM_LEN = cngh_pkg::MAX_GRAM_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cngh_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cngh_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [cngh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cngh_pkg::ROW_W-1:0]     cfg_data_i
);
  import cngh_pkg::*;

  localparam int unsigned WP_W  = $clog2(MAX_GRAM_LEN + 1);
  localparam int unsigned N_W   = (WP_W > GRAM_W) ? WP_W : GRAM_W;
  localparam int unsigned IDX_W = (MAX_GRAM_LEN > 1) ? $clog2(MAX_GRAM_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(RESULT_CAP + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_APPEND = 6'b000010,
    ST_HASH   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_RESULT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [GRAM_W-1:0] min_gram_q;
  logic [GRAM_W-1:0] max_gram_q;
  logic [ROW_W-1:0]  bucket_q;
  logic [ROW_W-1:0]  vocab_q;

  logic [CHAR_W-1:0] recent_q [MAX_GRAM_LEN];
  logic [WP_W-1:0]   wp_q, wp_d;
  logic              inside_q, inside_d;
  logic              op_open_q, op_open_d;
  logic              op_chr_q, op_chr_d;
  logic              op_close_q, op_close_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [N_W-1:0]    hi_q, hi_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [IDX_W-1:0]  kidx_q, kidx_d;
  logic [HASH_W-1:0] h_q, h_d;
  logic [ROW_W-1:0]  rem_q, rem_d;
  out_t              pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              shift_en;
  logic [CHAR_W-1:0] app_char;
  logic [WP_W-1:0]   wp_base;
  logic [WP_W-1:0]   wp_new;
  logic [N_W-1:0]    lo;
  logic [N_W-1:0]    hi_lim;
  logic [N_W-1:0]    hi;
  logic [HASH_W-1:0] h_next;
  out_t              new_item;
  logic              out_free;
  logic              advance;
  logic              in_sep;
  logic [CHAR_W-1:0] in_fold;
  logic              div_start;
  rem_stat_t         div_stat;
  logic [ROW_W-1:0]  div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gram_q <= MIN_GRAM_RST;
      max_gram_q <= MAX_GRAM_RST;
      bucket_q   <= BUCKET_COUNT_RST;
      vocab_q    <= VOCAB_WORDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_GRAM:     min_gram_q <= cfg_data_i[GRAM_W-1:0];
        CFG_MAX_GRAM:     max_gram_q <= cfg_data_i[GRAM_W-1:0];
        CFG_BUCKET_COUNT: bucket_q   <= cfg_data_i;
        CFG_VOCAB_WORDS:  vocab_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_sep  = in_data_i.char_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  assign in_fold = (in_data_i.char_byte inside {[CH_UPPER_A:CH_UPPER_Z]}) ?
                   in_data_i.char_byte + CASE_OFFSET : in_data_i.char_byte;

  assign app_char = op_open_q ? CH_OPEN : (op_chr_q ? char_q : CH_CLOSE);
  assign wp_base  = op_open_q ? '0 : wp_q;
  assign wp_new   = (wp_base < WP_W'(MAX_GRAM_LEN)) ? wp_base + 1'b1 : wp_base;
  assign lo       = (min_gram_q == '0) ? N_W'(1) : N_W'(min_gram_q);
  assign hi_lim   = (N_W'(max_gram_q) > N_W'(MAX_GRAM_LEN)) ? N_W'(MAX_GRAM_LEN)
                                                            : N_W'(max_gram_q);
  assign hi       = (hi_lim > N_W'(wp_new)) ? N_W'(wp_new) : hi_lim;
  assign h_next   = fnv_step(h_q, recent_q[kidx_q]);
  assign out_free = !out_valid_q || out_ready_i;

  assign new_item.row_index   = vocab_q + rem_q;
  assign new_item.gram_length = n_q[GRAM_W-1:0];
  assign new_item.last_of_run = 1'b0;

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    inside_d     = inside_q;
    op_open_d    = op_open_q;
    op_chr_d     = op_chr_q;
    op_close_d   = op_close_q;
    char_d       = char_q;
    hi_d         = hi_q;
    n_d          = n_q;
    kidx_d       = kidx_q;
    h_d          = h_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    count_d      = count_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    shift_en     = 1'b0;
    div_start    = 1'b0;
    advance      = 1'b0;
    in_ready_o   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          char_d     = in_fold;
          op_open_d  = !in_sep && !inside_q;
          op_chr_d   = !in_sep;
          op_close_d = in_sep ? inside_q : in_data_i.text_end;
          count_d    = '0;
          state_d    = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (op_open_q || op_chr_q || op_close_q) begin
          shift_en = 1'b1;
          wp_d     = wp_new;
          hi_d     = hi;
          if (op_open_q) begin
            op_open_d = 1'b0;
            inside_d  = 1'b1;
          end else if (op_chr_q) begin
            op_chr_d = 1'b0;
          end else begin
            op_close_d = 1'b0;
            inside_d   = 1'b0;
            wp_d       = '0;
          end
          if (lo <= hi) begin
            n_d     = lo;
            kidx_d  = IDX_W'(lo - 1'b1);
            h_d     = FNV_BASIS;
            state_d = ST_HASH;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_HASH: begin
        h_d = h_next;
        if (kidx_q == '0) begin
          if (bucket_q == '0) begin
            rem_d   = h_next[ROW_W-1:0];
            state_d = ST_RESULT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else begin
          kidx_d = kidx_q - 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          rem_d   = div_rem;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (count_q == CNT_W'(RESULT_CAP)) begin
          advance = 1'b1;
        end else if (!pend_valid_q) begin
          pend_d       = new_item;
          pend_valid_d = 1'b1;
          count_d      = count_q + 1'b1;
          advance      = 1'b1;
        end else if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          pend_d      = new_item;
          count_d     = count_q + 1'b1;
          advance     = 1'b1;
        end
        if (advance) begin
          if (n_q == hi_q) begin
            state_d = ST_APPEND;
          end else begin
            n_d     = n_q + 1'b1;
            kidx_d  = IDX_W'(n_q);
            h_d     = FNV_BASIS;
            state_d = ST_HASH;
          end
        end
      end
      ST_FINISH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          out_valid_d       = 1'b1;
          pend_valid_d      = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      inside_q     <= 1'b0;
      op_open_q    <= 1'b0;
      op_chr_q     <= 1'b0;
      op_close_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_GRAM_LEN; i++) begin
        recent_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      inside_q     <= inside_d;
      op_open_q    <= op_open_d;
      op_chr_q     <= op_chr_d;
      op_close_q   <= op_close_d;
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      if (shift_en) begin
        recent_q[0] <= app_char;
        for (int i = 1; i < MAX_GRAM_LEN; i++) begin
          recent_q[i] <= recent_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    hi_q   <= hi_d;
    n_q    <= n_d;
    kidx_q <= kidx_d;
    h_q    <= h_d;
    rem_q  <= rem_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  cngh_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (h_next),
    .divisor_i  (bucket_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!pend_valid_q && !op_open_q && !op_chr_q && !op_close_q))
    else $error("input ready with work still pending");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RESULT_CAP))
    else $error("result count above cap");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("remainder unit active outside divide state");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_stat.busy)
    else $error("remainder unit did not start");

endmodule
